// File: hdl/co2tc_pkg.sv
// co2tc_pkg: shared constants, types and conversion functions of the co2 trend block
`timescale 1ns / 1ps

package co2tc_pkg;

    // history geometry
    localparam int HISTORY_DEPTH = 320;
    localparam int RING_SIZE     = HISTORY_DEPTH - 1;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);

    // field and datapath widths
    localparam int PPM_W   = 16;
    localparam int AGE_W   = 9;
    localparam int CFG_W   = 5;
    localparam int SUM_W   = 15;
    localparam int CNT_W   = 5;
    localparam int CLP_W   = 11;
    localparam int NUM_W   = 22;
    localparam int DEN_W   = 15;
    localparam int QUO_W   = 8;
    localparam int STEP_W  = $clog2(QUO_W);
    localparam int HGT_W   = 7;
    localparam int HVAL_W  = 8;
    localparam int COLOR_W = 16;

    // item codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // ppm thresholds and scaling
    localparam logic [PPM_W-1:0]  PPM_LOW    = 16'd400;
    localparam logic [PPM_W-1:0]  PPM_MID    = 16'd1200;
    localparam logic [PPM_W-1:0]  PPM_HIGH   = 16'd2000;
    localparam logic [DEN_W-1:0]  PPM_SPAN   = 15'd1600;
    localparam logic [HVAL_W-1:0] EMPTY_MARK = 8'd128;
    localparam logic [HVAL_W-1:0] POINT_MAX  = 8'd127;
    localparam logic [CFG_W-1:0]  PERIOD_MIN = 5'd1;
    localparam logic [CFG_W-1:0]  PERIOD_MAX = 5'd16;
    localparam logic [CFG_W-1:0]  PERIOD_RST = 5'd5;

    // x / 25 as a reciprocal multiply, exact for x below 4096
    localparam logic [10:0] DIV25_MUL   = 11'd1311;
    localparam int          DIV25_SHIFT = 15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PREP,
        ST_DIV,
        ST_RDWAIT,
        ST_DONE
    } t_state;

    // floor(x / 25) for a 12-bit x
    function automatic logic [7:0] div25(input logic [11:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'(DIV25_MUL);
        return prod[DIV25_SHIFT +: 8];
    endfunction

    // bar height of a clamped sample, 0..127
    function automatic logic [HGT_W-1:0] height_of(input logic [CLP_W-1:0] c);
        logic [11:0] x;
        logic [7:0]  t;
        x = {1'b0, c - CLP_W'(PPM_LOW)} << 1;
        t = div25(x);
        return (t > POINT_MAX) ? HGT_W'(POINT_MAX) : t[HGT_W-1:0];
    endfunction

    // rgb565 color of a raw sample
    function automatic logic [COLOR_W-1:0] color_of(input logic [PPM_W-1:0] p);
        logic [4:0]  red;
        logic [5:0]  green;
        logic [11:0] x;
        logic [7:0]  t;
        red   = 5'd0;
        green = 6'd0;
        x     = 12'd0;
        t     = 8'd0;
        if (p > PPM_MID) begin
            red = 5'd31;
            if (p <= PPM_HIGH) begin
                x = 12'(PPM_HIGH - p) << 1;
                t = div25(x);
                green = (t != 8'd0) ? 6'(t - 8'd1) : 6'd0;
            end
        end else begin
            green = 6'd63;
            if (p >= PPM_LOW) begin
                x = 12'(p - PPM_LOW);
                t = div25(x);
                red = (t != 8'd0) ? 5'(t - 8'd1) : 5'd0;
            end
        end
        return {red, green, 5'd0};
    endfunction

endpackage

// File: hdl/co2tc_div.sv
// co2tc_div: restoring divider, one quotient bit per cycle, quotient known to fit 8 bits
`timescale 1ns / 1ps

module co2tc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [co2tc_pkg::NUM_W-1:0]     i_num,
    input  logic [co2tc_pkg::DEN_W-1:0]     i_den,
    output logic                            o_done,
    output logic [co2tc_pkg::QUO_W-1:0]     o_quot
);

    localparam int TRY_W = co2tc_pkg::DEN_W + co2tc_pkg::QUO_W;

    logic                              r_busy;
    logic                              r_done;
    logic [co2tc_pkg::STEP_W-1:0]      r_step;
    logic [co2tc_pkg::NUM_W-1:0]       r_rem;
    logic [co2tc_pkg::DEN_W-1:0]       r_den;
    logic [co2tc_pkg::QUO_W-1:0]       r_quot;
    logic [TRY_W-1:0]                  trial;
    logic                              fits;

    // shifted divisor for the current quotient bit
    always_comb begin
        trial = TRY_W'(r_den) << r_step;
        fits  = TRY_W'(r_rem) >= trial;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= co2tc_pkg::STEP_W'(co2tc_pkg::QUO_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy && fits) begin
            r_rem          <= co2tc_pkg::NUM_W'(TRY_W'(r_rem) - trial);
            r_quot[r_step] <= 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: hdl/co2_trend_color_and_history.sv
// co2_trend_color_and_history: top level, sample color, live height and averaged history ring
//
// Input stream: tuser is the item kind (0 sample, 1 history read), tdata carries
// ppm in [15:0] and the history age in [24:16]. Every input item gives exactly
// one output item: tdata has color565 [15:0], live height [22:16] and the
// history value [30:23]; tuser is set when the sample completed a history point.
// The config channel sets samples per point (always ready, write only when idle).
// One item is worked at a time. From acceptance to a valid output, a sample that
// does not complete a point passes EXEC and DONE, a history read of a stored point
// also waits in RDWAIT for the synchronous memory, and a sample that completes a
// point goes through PREP and DIV, where the 8-step divider computes the point mean.
// The input is ready again the cycle after the result lands in the output
// register, so a new item is taken while the previous result waits.
// A stalled receiver holds the output register; the block then parks its
// finished result until that register frees up.
// Reset (synchronous, active low) empties the history at once: a fill count marks
// how many ring entries hold points, no clearing pass is needed.
`timescale 1ns / 1ps

module co2_trend_color_and_history (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // ppm[15:0], age_index[24:16], zeros
    input  logic        i_s_axis_tuser,   // kind[0]
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // color565[15:0], live_height[22:16],
                                          // history_value[30:23], zero[31]
    output logic        o_m_axis_tuser,   // point_pushed[0]
    // samples per point register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    localparam int PTR_W = co2tc_pkg::PTR_W;

    co2tc_pkg::t_state                  r_state, n_state;
    logic [co2tc_pkg::CFG_W-1:0]        r_cfg;
    logic                               r_kind;
    logic [co2tc_pkg::PPM_W-1:0]        r_ppm;
    logic [co2tc_pkg::AGE_W-1:0]        r_age;
    logic [co2tc_pkg::SUM_W-1:0]        r_sum;
    logic [co2tc_pkg::CNT_W-1:0]        r_cnt;
    logic [PTR_W-1:0]                   r_ptr;
    logic [PTR_W-1:0]                   r_fill;
    logic [co2tc_pkg::HVAL_W-1:0]       r_lat_height;
    logic [co2tc_pkg::COLOR_W-1:0]      r_lat_color;
    logic [co2tc_pkg::HVAL_W-1:0]       r_hval;
    logic                               r_pushed;
    logic                               r_out_valid;
    logic [31:0]                        r_out_data;
    logic                               r_out_user;
    logic [co2tc_pkg::HVAL_W-1:0]       r_rd_data;
    logic [co2tc_pkg::HVAL_W-1:0]       mem [co2tc_pkg::RING_SIZE];

    // control decoded from state
    logic in_ready, div_start, mem_re, mem_we, out_load;

    // sample path
    logic [co2tc_pkg::CLP_W-1:0]        clamped;
    logic [co2tc_pkg::SUM_W-1:0]        n_sum;
    logic [co2tc_pkg::CNT_W-1:0]        n_cnt;
    logic [co2tc_pkg::CFG_W-1:0]        period;
    logic                               push;

    // point mean
    logic [co2tc_pkg::SUM_W-1:0]        diff;
    logic [co2tc_pkg::NUM_W-1:0]        div_num;
    logic [co2tc_pkg::DEN_W-1:0]        div_den;
    logic                               div_done;
    logic [co2tc_pkg::QUO_W-1:0]        div_quot;
    logic [co2tc_pkg::HVAL_W-1:0]       point_val;

    // ring addressing
    logic                               age_zero, age_in, age_filled;
    logic [PTR_W-1:0]                   back;
    logic [PTR_W:0]                     rd_sum;
    logic [PTR_W-1:0]                   rd_idx;
    logic [PTR_W-1:0]                   wr_idx;
    logic [co2tc_pkg::HGT_W-1:0]        height_out;

    // sample clamp, running sum and period check
    always_comb begin
        if (r_ppm < co2tc_pkg::PPM_LOW) begin
            clamped = co2tc_pkg::CLP_W'(co2tc_pkg::PPM_LOW);
        end else if (r_ppm > co2tc_pkg::PPM_HIGH) begin
            clamped = co2tc_pkg::CLP_W'(co2tc_pkg::PPM_HIGH);
        end else begin
            clamped = r_ppm[co2tc_pkg::CLP_W-1:0];
        end
        n_sum = r_sum + co2tc_pkg::SUM_W'(clamped);
        n_cnt = r_cnt + 1'b1;
        if (r_cfg < co2tc_pkg::PERIOD_MIN) begin
            period = co2tc_pkg::PERIOD_MIN;
        end else if (r_cfg > co2tc_pkg::PERIOD_MAX) begin
            period = co2tc_pkg::PERIOD_MAX;
        end else begin
            period = r_cfg;
        end
        push = n_cnt >= period;
    end

    // divider operands: (sum - 400 n) * 127 over 1600 n
    always_comb begin
        diff    = r_sum - co2tc_pkg::SUM_W'(co2tc_pkg::PPM_LOW * co2tc_pkg::PPM_W'(r_cnt));
        div_num = co2tc_pkg::NUM_W'(diff) * co2tc_pkg::NUM_W'(co2tc_pkg::POINT_MAX);
        div_den = co2tc_pkg::PPM_SPAN * co2tc_pkg::DEN_W'(r_cnt);
        point_val = (div_quot > co2tc_pkg::POINT_MAX) ? co2tc_pkg::POINT_MAX : div_quot;
    end

    co2tc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // ring index of a read age and of the next push
    always_comb begin
        age_zero   = r_age == '0;
        age_in     = 32'(r_age) < co2tc_pkg::HISTORY_DEPTH;
        age_filled = 32'(r_age) <= 32'(r_fill);
        back       = PTR_W'(r_age - 1'b1);
        rd_sum     = {1'b0, r_ptr} + (PTR_W + 1)'(co2tc_pkg::RING_SIZE) - {1'b0, back};
        if (rd_sum >= (PTR_W + 1)'(co2tc_pkg::RING_SIZE)) begin
            rd_idx = PTR_W'(rd_sum - (PTR_W + 1)'(co2tc_pkg::RING_SIZE));
        end else begin
            rd_idx = rd_sum[PTR_W-1:0];
        end
        if (r_ptr == PTR_W'(co2tc_pkg::RING_SIZE - 1)) begin
            wr_idx = '0;
        end else begin
            wr_idx = r_ptr + 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            co2tc_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) n_state = co2tc_pkg::ST_EXEC;
            end
            co2tc_pkg::ST_EXEC: begin
                if (r_kind == co2tc_pkg::KIND_SAMPLE) begin
                    n_state = push ? co2tc_pkg::ST_PREP : co2tc_pkg::ST_DONE;
                end else begin
                    n_state = mem_re ? co2tc_pkg::ST_RDWAIT : co2tc_pkg::ST_DONE;
                end
            end
            co2tc_pkg::ST_PREP:   n_state = co2tc_pkg::ST_DIV;
            co2tc_pkg::ST_DIV: begin
                if (div_done) n_state = co2tc_pkg::ST_DONE;
            end
            co2tc_pkg::ST_RDWAIT: n_state = co2tc_pkg::ST_DONE;
            co2tc_pkg::ST_DONE: begin
                if (out_load) n_state = co2tc_pkg::ST_IDLE;
            end
            default:              n_state = co2tc_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            co2tc_pkg::ST_IDLE: in_ready = 1'b1;
            co2tc_pkg::ST_EXEC: begin
                mem_re = (r_kind == co2tc_pkg::KIND_READ) && !age_zero && age_in
                         && age_filled;
            end
            co2tc_pkg::ST_PREP: div_start = 1'b1;
            co2tc_pkg::ST_DIV:  mem_we = div_done;
            co2tc_pkg::ST_DONE: out_load = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= co2tc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= co2tc_pkg::PERIOD_RST;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // input item capture
    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            r_kind <= i_s_axis_tuser;
            r_ppm  <= i_s_axis_tdata[15:0];
            r_age  <= i_s_axis_tdata[24:16];
        end
    end

    // block state: latest sample, running sum, ring pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_cnt        <= '0;
            r_ptr        <= '0;
            r_fill       <= '0;
            r_lat_height <= co2tc_pkg::EMPTY_MARK;
            r_lat_color  <= '0;
        end else if (r_state == co2tc_pkg::ST_EXEC && r_kind == co2tc_pkg::KIND_SAMPLE) begin
            r_lat_height <= co2tc_pkg::HVAL_W'(co2tc_pkg::height_of(clamped));
            r_lat_color  <= co2tc_pkg::color_of(r_ppm);
            r_sum        <= n_sum;
            r_cnt        <= n_cnt;
        end else if (mem_we) begin
            r_ptr <= wr_idx;
            r_sum <= '0;
            r_cnt <= '0;
            if (r_fill != PTR_W'(co2tc_pkg::RING_SIZE)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // result fields of the item in flight
    always_ff @(posedge i_clk) begin
        case (r_state)
            co2tc_pkg::ST_EXEC: begin
                r_pushed <= (r_kind == co2tc_pkg::KIND_SAMPLE) && push;
                if (r_kind == co2tc_pkg::KIND_READ && age_zero) begin
                    r_hval <= r_lat_height;
                end else begin
                    r_hval <= co2tc_pkg::EMPTY_MARK;
                end
            end
            co2tc_pkg::ST_DIV: begin
                if (div_done) r_hval <= point_val;
            end
            co2tc_pkg::ST_RDWAIT: r_hval <= r_rd_data;
            default: ;
        endcase
    end

    // history ring memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_idx] <= point_val;
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_idx];
        end
    end

    // output register
    assign height_out = (r_lat_height == co2tc_pkg::EMPTY_MARK) ? '0
                        : r_lat_height[co2tc_pkg::HGT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {1'b0, r_hval, height_out, r_lat_color};
            r_out_user <= r_pushed;
        end
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_cfg_ready     = 1'b1;

endmodule

// File: test/testbench.sv
// testbench: stream-driven check of the co2 trend color, live height and averaged history
`timescale 1ns / 1ps

module testbench;

    localparam int STUCK_LIMIT = 3000;

    // expected fields of one result item
    typedef struct packed {
        logic [15:0] color;
        logic [6:0]  height;
        logic        pushed;
        logic [7:0]  hval;
    } t_trend_result;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_READ,
        ROW_PERIOD
    } t_row_op;

    typedef struct {
        t_row_op       op;
        logic [15:0]   ppm;
        logic [8:0]    age;
        logic [4:0]    period;
        bit            typed;
        t_trend_result want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data;

    // predictor state
    logic [7:0]    ring_mirror [co2tc_pkg::RING_SIZE];
    int unsigned   newest_slot;
    int unsigned   ppm_sum;
    int unsigned   ppm_count;
    int unsigned   last_height;
    logic [15:0]   last_color;
    logic [4:0]    period_reg;

    t_trend_result pending_results[$];
    t_stim_row     directed_rows[$];
    int            errors;
    int            results_seen;
    int            send_calm;
    int            recv_hold;
    int            recv_calm;
    bit            long_hold_done;

    co2_trend_color_and_history uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // green-yellow-red ramp of a raw ppm value
    function automatic logic [15:0] ppm_to_color565(input int unsigned p);
        int unsigned red;
        int unsigned green;
        int unsigned steps;
        if (p > 1200) begin
            red   = 31;
            green = 0;
            if (p <= 2000) begin
                steps = ((2000 - p) * 2) / 25;
                green = (steps > 0) ? steps - 1 : 0;
            end
        end else begin
            green = 63;
            red   = 0;
            if (p >= 400) begin
                steps = (p - 400) / 25;
                red   = (steps > 0) ? steps - 1 : 0;
            end
        end
        return {red[4:0], green[5:0], 5'd0};
    endfunction

    // advance the predictor by one item and return the result it should give
    function automatic t_trend_result apply_item(input logic kind, input logic [15:0] ppm,
                                                 input logic [8:0] age);
        t_trend_result r;
        int unsigned   clamped;
        int unsigned   h;
        int unsigned   per;
        int unsigned   n;
        int unsigned   v;
        r.pushed = 1'b0;
        r.hval   = co2tc_pkg::EMPTY_MARK;
        if (kind == co2tc_pkg::KIND_SAMPLE) begin
            clamped = ppm;
            if (clamped < 400) clamped = 400;
            if (clamped > 2000) clamped = 2000;
            h = ((clamped - 400) * 2) / 25;
            if (h > 127) h = 127;
            last_height = h;
            last_color  = ppm_to_color565(ppm);
            ppm_sum   += clamped;
            ppm_count += 1;
            // out-of-range periods saturate to 1..16
            per = period_reg;
            if (per < 1) per = 1;
            if (per > 16) per = 16;
            if (ppm_count >= per) begin
                n = ppm_count;
                v = ((ppm_sum - 400 * n) * 127) / (1600 * n);
                if (v > 127) v = 127;
                newest_slot = (newest_slot + 1) % co2tc_pkg::RING_SIZE;
                ring_mirror[newest_slot] = v[7:0];
                ppm_sum   = 0;
                ppm_count = 0;
                r.pushed  = 1'b1;
                r.hval    = v[7:0];
            end
        end else begin
            if (age == 9'd0)
                r.hval = last_height[7:0];
            else if (age < co2tc_pkg::HISTORY_DEPTH)
                r.hval = ring_mirror[(newest_slot + co2tc_pkg::RING_SIZE - (age - 1))
                                     % co2tc_pkg::RING_SIZE];
        end
        r.color  = last_color;
        r.height = (last_height == co2tc_pkg::EMPTY_MARK) ? 7'd0 : last_height[6:0];
        return r;
    endfunction

    // sender gap: mostly none, some short, a few long, with calm stretches
    function automatic int pick_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) send_calm = $urandom_range(20, 60);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one item, called and returning at a falling edge
    task automatic send_item(input logic kind, input logic [15:0] ppm, input logic [8:0] age,
                             input bit typed, input t_trend_result want);
        int            gap;
        t_trend_result got;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {7'd0, age, ppm};
        do @(posedge i_clk); while (!o_s_axis_tready);
        got = apply_item(kind, ppm, age);
        pending_results.push_back(typed ? want : got);
        @(negedge i_clk);
    endtask

    // write samples per point once the block has drained
    task automatic write_period(input logic [4:0] value);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        period_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, calm stretches and one long hold-off
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold--;
            i_m_axis_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 120) begin
            long_hold_done = 1'b1;
            recv_hold = 300;
            i_m_axis_tready <= 1'b0;
        end else if (recv_calm > 0) begin
            recv_calm--;
            i_m_axis_tready <= 1'b1;
        end else begin
            case ($urandom_range(0, 99)) inside
                [0:1]:   begin
                    recv_calm = $urandom_range(20, 60);
                    i_m_axis_tready <= 1'b1;
                end
                [2:69]:  i_m_axis_tready <= 1'b1;
                [70:94]: begin
                    recv_hold = $urandom_range(0, 2);
                    i_m_axis_tready <= 1'b0;
                end
                default: begin
                    recv_hold = $urandom_range(10, 40);
                    i_m_axis_tready <= 1'b0;
                end
            endcase
        end
    end

    // compare every result item with the oldest expectation
    always @(posedge i_clk) begin
        t_trend_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item tdata %h tuser %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[15:0] !== want.color) begin
                    errors++;
                    $display("%0t: color565 expected %h got %h",
                             $time, want.color, o_m_axis_tdata[15:0]);
                end
                if (o_m_axis_tdata[22:16] !== want.height) begin
                    errors++;
                    $display("%0t: live_height expected %0d got %0d",
                             $time, want.height, o_m_axis_tdata[22:16]);
                end
                if (o_m_axis_tdata[30:23] !== want.hval) begin
                    errors++;
                    $display("%0t: history_value expected %0d got %0d",
                             $time, want.hval, o_m_axis_tdata[30:23]);
                end
                if (o_m_axis_tuser !== want.pushed) begin
                    errors++;
                    $display("%0t: point_pushed expected %b got %b",
                             $time, want.pushed, o_m_axis_tuser);
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("co2_trend_color_and_history test failed");
        $finish;
    end

    // stimulus
    initial begin
        t_stim_row   row;
        logic        kind;
        logic [15:0] ppm;
        logic [8:0]  age;
        logic [4:0]  per;
        int          count;
        int          sample_pct;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 32'd0;
        i_s_axis_tuser  = co2tc_pkg::KIND_SAMPLE;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = 5'd0;
        errors          = 0;
        results_seen    = 0;
        send_calm       = 0;
        recv_hold       = 0;
        recv_calm       = 0;
        long_hold_done  = 1'b0;

        // predictor after reset
        foreach (ring_mirror[i]) ring_mirror[i] = co2tc_pkg::EMPTY_MARK;
        newest_slot = 0;
        ppm_sum     = 0;
        ppm_count   = 0;
        last_height = co2tc_pkg::EMPTY_MARK;
        last_color  = 16'h0000;
        period_reg  = co2tc_pkg::PERIOD_RST;

        // op, ppm, age, period, typed, {color, height, pushed, hval}
        directed_rows.push_back('{ROW_READ,   16'd0,     9'd0,   5'd0,  1'b1,
                                  {16'h0000, 7'd0,   1'b0, 8'd128}});
        directed_rows.push_back('{ROW_READ,   16'd0,     9'd1,   5'd0,  1'b1,
                                  {16'h0000, 7'd0,   1'b0, 8'd128}});
        directed_rows.push_back('{ROW_READ,   16'd0,     9'd319, 5'd0,  1'b1,
                                  {16'h0000, 7'd0,   1'b0, 8'd128}});
        directed_rows.push_back('{ROW_READ,   16'hFFFF,  9'd511, 5'd0,  1'b1,
                                  {16'h0000, 7'd0,   1'b0, 8'd128}});
        directed_rows.push_back('{ROW_SAMPLE, 16'd0,     9'd0,   5'd0,  1'b1,
                                  {16'h07E0, 7'd0,   1'b0, 8'd128}});
        directed_rows.push_back('{ROW_SAMPLE, 16'd400,   9'd511, 5'd0,  1'b1,
                                  {16'h07E0, 7'd0,   1'b0, 8'd128}});
        directed_rows.push_back('{ROW_SAMPLE, 16'd1200,  9'd0,   5'd0,  1'b1,
                                  {16'hFFE0, 7'd64,  1'b0, 8'd128}});
        directed_rows.push_back('{ROW_SAMPLE, 16'd2000,  9'd0,   5'd0,  1'b1,
                                  {16'hF800, 7'd127, 1'b0, 8'd128}});
        // fifth sample completes the first point
        directed_rows.push_back('{ROW_SAMPLE, 16'hFFFF,  9'd0,   5'd0,  1'b1,
                                  {16'hF800, 7'd127, 1'b1, 8'd63}});
        directed_rows.push_back('{ROW_READ,   16'd0,     9'd1,   5'd0,  1'b1,
                                  {16'hF800, 7'd127, 1'b0, 8'd63}});
        directed_rows.push_back('{ROW_READ,   16'd0,     9'd2,   5'd0,  1'b1,
                                  {16'hF800, 7'd127, 1'b0, 8'd128}});
        directed_rows.push_back('{ROW_READ,   16'd0,     9'd0,   5'd0,  1'b1,
                                  {16'hF800, 7'd127, 1'b0, 8'd127}});
        directed_rows.push_back('{ROW_SAMPLE, 16'd1201,  9'd0,   5'd0,  1'b0, 32'd0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd425,   9'd0,   5'd0,  1'b0, 32'd0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd450,   9'd0,   5'd0,  1'b0, 32'd0});
        // period lowered with three samples already summed
        directed_rows.push_back('{ROW_PERIOD, 16'd0,     9'd0,   5'd1,  1'b0, 32'd0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd1999,  9'd0,   5'd0,  1'b0, 32'd0});
        // a full-scale mean reaches the top value 127
        directed_rows.push_back('{ROW_SAMPLE, 16'd2000,  9'd0,   5'd0,  1'b1,
                                  {16'hF800, 7'd127, 1'b1, 8'd127}});
        directed_rows.push_back('{ROW_SAMPLE, 16'd399,   9'd0,   5'd0,  1'b0, 32'd0});
        directed_rows.push_back('{ROW_PERIOD, 16'd0,     9'd0,   5'd0,  1'b0, 32'd0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd1800,  9'd0,   5'd0,  1'b0, 32'd0});
        directed_rows.push_back('{ROW_PERIOD, 16'd0,     9'd0,   5'd31, 1'b0, 32'd0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd800,   9'd0,   5'd0,  1'b0, 32'd0});
        directed_rows.push_back('{ROW_SAMPLE, 16'd1600,  9'd0,   5'd0,  1'b0, 32'd0});
        directed_rows.push_back('{ROW_READ,   16'd0,     9'd3,   5'd0,  1'b0, 32'd0});

        // hold synchronous reset, then release it
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.op == ROW_PERIOD)
                write_period(row.period);
            else
                send_item((row.op == ROW_READ) ? co2tc_pkg::KIND_READ : co2tc_pkg::KIND_SAMPLE,
                          row.ppm, row.age, row.typed, row.want);
        end

        // random phases, each under its own period setting
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin per = 5'd1;  count = 330; sample_pct = 98; end
                1: begin per = 5'd16; count = 20;  sample_pct = 85; end
                2: begin per = 5'd0;  count = 10;  sample_pct = 80; end
                3: begin per = 5'd31; count = 20;  sample_pct = 85; end
                4: begin per = 5'($urandom_range(2, 15)); count = 10; sample_pct = 80; end
                default: begin per = co2tc_pkg::PERIOD_RST; count = 10; sample_pct = 50; end
            endcase
            write_period(per);
            for (int n = 0; n < count; n++) begin
                kind = ($urandom_range(0, 99) < sample_pct) ? co2tc_pkg::KIND_SAMPLE
                                                             : co2tc_pkg::KIND_READ;
                case ($urandom_range(0, 99)) inside
                    [0:69]:  ppm = 16'($urandom_range(300, 2100));
                    [70:84]: ppm = 16'($urandom_range(0, 65535));
                    default: ppm = 16'($urandom_range(1180, 1220));
                endcase
                if ($urandom_range(0, 99) < 80)
                    age = 9'($urandom_range(0, 330));
                else
                    age = 9'($urandom_range(0, 511));
                send_item(kind, ppm, age, 1'b0, 32'd0);
            end
        end

        // drain and let the pipeline settle
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("co2_trend_color_and_history test passed");
        else
            $display("co2_trend_color_and_history test failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/co2tc_pkg.sv
hdl/co2tc_div.sv
hdl/co2_trend_color_and_history.sv
test/testbench.sv
